// ----- design/pmpt_pkg.sv -----
// Package for the PS/2 mouse packet tracker.
// Holds the command codes, the front-end phase states and fixed constants.
// No dependencies; used by pmpt_front, pmpt_back, the top level and the testbench.
package pmpt_pkg;

   localparam int CSR_BITS = 13;
   localparam int QUEUE_DEPTH = 2;

   localparam int HDR_ALWAYS_ONE = 3;
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;

   localparam logic [CSR_BITS-1:0] WIDTH_RESET = 13'd800;
   localparam logic [CSR_BITS-1:0] HEIGHT_RESET = 13'd600;
   localparam logic [15:0] CURSOR_X_RESET = 16'd400;
   localparam logic [15:0] CURSOR_Y_RESET = 16'd300;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_XMOVE  = 2'd1,
      PH_YMOVE  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_HEADER = 3'd1,
      OP_XMOVE  = 3'd2,
      OP_YMOVE  = 3'd3,
      OP_DROP   = 3'd4
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

endpackage

// ----- design/pmpt_queue.sv -----
// Small register queue used between the tracker's front end, back end and result port.
// Depends on nothing; DEPTH must be a power of two of at least two.
module pmpt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- design/pmpt_front.sv -----
// Front end of the PS/2 mouse packet tracker: tracks the byte phase of a packet
// and turns each accepted request into a command. Depends on pmpt_pkg.
module pmpt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_type,
   input  logic [7:0]        req_rx_byte,
   output logic              req_full,
   input  logic              cmd_full,
   output logic              cmd_push,
   output pmpt_pkg::cmd_type cmd
);

   pmpt_pkg::phase_type phase_ff, phase_in;
   logic                accept;
   logic                marker;

   assign accept = req_push && !cmd_full;
   assign req_full = cmd_full;
   assign cmd_push = accept;
   assign marker = req_rx_byte[pmpt_pkg::HDR_ALWAYS_ONE];

   always_comb begin
      phase_in = phase_ff;
      if (accept && !req_type) begin
         case (phase_ff)
            pmpt_pkg::PH_XMOVE: phase_in = pmpt_pkg::PH_YMOVE;
            pmpt_pkg::PH_YMOVE: phase_in = pmpt_pkg::PH_HEADER;
            default: phase_in = marker ? pmpt_pkg::PH_XMOVE : pmpt_pkg::PH_HEADER;
         endcase
      end
   end

   always_comb begin
      cmd.data = req_rx_byte;
      if (req_type) begin
         cmd.op = pmpt_pkg::OP_READ;
      end else begin
         case (phase_ff)
            pmpt_pkg::PH_XMOVE: cmd.op = pmpt_pkg::OP_XMOVE;
            pmpt_pkg::PH_YMOVE: cmd.op = pmpt_pkg::OP_YMOVE;
            default: cmd.op = marker ? pmpt_pkg::OP_HEADER : pmpt_pkg::OP_DROP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pmpt_pkg::PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- design/pmpt_back.sv -----
// Back end of the PS/2 mouse packet tracker: executes commands, keeps the cursor,
// buttons, changed flag and screen size, and builds one result per command.
// Depends on pmpt_pkg.
module pmpt_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic                      csr_index,
   input  logic [12:0]               csr_wdata,
   input  pmpt_pkg::cmd_type         cmd,
   input  logic                      cmd_empty,
   output logic                      cmd_pop,
   input  logic                      res_full,
   output logic                      res_push,
   output logic [2*COORD_BITS+4:0]   res_data
);

   localparam int SW = ((COORD_BITS > pmpt_pkg::CSR_BITS) ? COORD_BITS : pmpt_pkg::CSR_BITS) + 2;
   localparam logic [SW-1:0] CAP = {{(SW-1){1'b0}}, 1'b1} << COORD_BITS;
   localparam logic [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1};

   logic [pmpt_pkg::CSR_BITS-1:0] width_ff, height_ff;
   logic [7:0]                    header_ff, header_in;
   logic [7:0]                    xmove_ff, xmove_in;
   logic [COORD_BITS-1:0]         cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]         cursor_y_ff, cursor_y_in;
   logic [2:0]                    buttons_ff, buttons_in;
   logic                          changed_ff, changed_in;
   logic signed [SW-1:0]          dx, dy;
   logic [COORD_BITS-1:0]         new_x, new_y;
   logic                          flag_out;
   logic                          done;

   function automatic logic [COORD_BITS-1:0] move_clamp(
      input logic [COORD_BITS-1:0]         pos,
      input logic signed [SW-1:0]          delta,
      input logic [pmpt_pkg::CSR_BITS-1:0] size
   );
      logic [SW-1:0]        sz;
      logic signed [SW-1:0] lim;
      logic signed [SW-1:0] sum;
      logic [COORD_BITS-1:0] r;
      sz = {{(SW-pmpt_pkg::CSR_BITS){1'b0}}, size};
      if (sz > CAP) begin
         sz = CAP;
      end
      lim = signed'(sz - ONE);
      sum = signed'({{(SW-COORD_BITS){1'b0}}, pos}) + delta;
      if (size == '0) begin
         r = '0;
      end else if (sum[SW-1]) begin
         r = '0;
      end else if (sum > lim) begin
         r = lim[COORD_BITS-1:0];
      end else begin
         r = sum[COORD_BITS-1:0];
      end
      return r;
   endfunction

   assign cmd_pop = !cmd_empty && !res_full;
   assign res_push = cmd_pop;

   assign dx = signed'({{(SW-8){header_ff[pmpt_pkg::HDR_X_SIGN]}}, xmove_ff});
   assign dy = -signed'({{(SW-8){header_ff[pmpt_pkg::HDR_Y_SIGN]}}, cmd.data});
   assign new_x = move_clamp(cursor_x_ff, dx, width_ff);
   assign new_y = move_clamp(cursor_y_ff, dy, height_ff);

   always_comb begin
      header_in = header_ff;
      xmove_in = xmove_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      buttons_in = buttons_ff;
      changed_in = changed_ff;
      flag_out = changed_ff;
      done = 1'b0;
      if (cmd_pop) begin
         case (cmd.op)
            pmpt_pkg::OP_READ: begin
               changed_in = 1'b0;
            end
            pmpt_pkg::OP_HEADER: begin
               header_in = cmd.data;
            end
            pmpt_pkg::OP_XMOVE: begin
               xmove_in = cmd.data;
            end
            pmpt_pkg::OP_YMOVE: begin
               cursor_x_in = new_x;
               cursor_y_in = new_y;
               buttons_in = header_ff[2:0];
               changed_in = 1'b1;
               flag_out = 1'b1;
               done = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign res_data = {cursor_x_in, cursor_y_in, buttons_in, flag_out, done};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= pmpt_pkg::WIDTH_RESET;
         height_ff <= pmpt_pkg::HEIGHT_RESET;
         header_ff <= '0;
         xmove_ff <= '0;
         cursor_x_ff <= pmpt_pkg::CURSOR_X_RESET[COORD_BITS-1:0];
         cursor_y_ff <= pmpt_pkg::CURSOR_Y_RESET[COORD_BITS-1:0];
         buttons_ff <= '0;
         changed_ff <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == pmpt_pkg::CSR_WIDTH)) begin
            width_ff <= csr_wdata;
         end
         if (csr_valid && (csr_index == pmpt_pkg::CSR_HEIGHT)) begin
            height_ff <= csr_wdata;
         end
         header_ff <= header_in;
         xmove_ff <= xmove_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         buttons_ff <= buttons_in;
         changed_ff <= changed_in;
      end
   end

endmodule

// ----- design/ps2_mouse_packet_tracker_top.sv -----
// Top level of the PS/2 mouse packet tracker.
// Instantiates pmpt_front, two pmpt_queue instances and pmpt_back; uses pmpt_pkg.
//
// Requests enter through a queue-style port: an item transfers when req_push is
// high and req_full is low. req_type 0 carries a received mouse byte, req_type 1
// asks for the position and clears the changed flag. Every request yields
// exactly one result. Results leave through a queue-style port: the oldest
// result is on the rsp_ ports while rsp_empty is low and transfers when rsp_pop
// is high. The csr_ port writes screen width (index 0) and height (index 1);
// csr_ready is always high; the user must make writes while the block is idle;
// the block does not enforce this. The front end classifies each byte by packet
// phase and places a command in a two-entry queue; the back end executes one
// command per cycle while the result queue is not full and writes the result into
// a two-entry result queue. Both queues are registered, and the block sustains
// one request per cycle while results are taken. When the result side stalls,
// both queues fill and req_full rises after at most four waiting requests.
// Reset empties both queues and restores the cursor to its start position, the
// screen size to 800 by 600 and the flag to zero.
module ps2_mouse_packet_tracker_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_type,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COORD_BITS-1:0] rsp_pos_x,
   output logic [COORD_BITS-1:0] rsp_pos_y,
   output logic [2:0]            rsp_button_bits,
   output logic                  rsp_moved_flag,
   output logic                  rsp_packet_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [12:0]           csr_wdata
);

   localparam int RW = 2 * COORD_BITS + 5;
   localparam int CMW = $bits(pmpt_pkg::cmd_type);

   pmpt_pkg::cmd_type front_cmd, back_cmd;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic              res_push, res_full;
   logic [RW-1:0]     res_wdata, res_rdata;

   assign csr_ready = 1'b1;

   pmpt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd         (front_cmd)
   );

   pmpt_queue #(
      .WIDTH (CMW),
      .DEPTH (pmpt_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (front_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (back_cmd)
   );

   pmpt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_wdata)
   );

   pmpt_queue #(
      .WIDTH (RW),
      .DEPTH (pmpt_pkg::QUEUE_DEPTH)
   ) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .full  (res_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (res_rdata)
   );

   assign rsp_pos_x = res_rdata[RW-1 -: COORD_BITS];
   assign rsp_pos_y = res_rdata[RW-1-COORD_BITS -: COORD_BITS];
   assign rsp_button_bits = res_rdata[4:2];
   assign rsp_moved_flag = res_rdata[1];
   assign rsp_packet_done = res_rdata[0];

endmodule

// ----- design/pmpt_checker.sv -----
// Port-level checker for the PS/2 mouse packet tracker, bound to the top level.
// Depends only on the ports of ps2_mouse_packet_tracker_top.
module pmpt_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [COORD_BITS-1:0] rsp_pos_x,
   input logic [COORD_BITS-1:0] rsp_pos_y,
   input logic [2:0]            rsp_button_bits,
   input logic                  rsp_moved_flag,
   input logic                  rsp_packet_done
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_done_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_packet_done) |-> rsp_moved_flag)
      else $error("completed packet without moved flag");

   a_result_stays: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result vanished without a transfer");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_button_bits) && $stable(rsp_packet_done))
      else $error("waiting result changed while stalled");

endmodule

bind ps2_mouse_packet_tracker_top pmpt_checker #(
   .COORD_BITS (COORD_BITS)
) u_checker (.*);

// ----- dv/ps2_mouse_packet_tracker_top_test.sv -----
// Self-checking testbench for ps2_mouse_packet_tracker_top.
// A local tracker model predicts every report and the checker compares the reports field by field.
// Depends on pmpt_pkg and the design files; needs nothing else.
module ps2_mouse_packet_tracker_top_test;

   localparam int COORD_BITS = 12;
   localparam int STALL_LIMIT = 1000;
   localparam int ITEMS_PER_PHASE = 120;

   typedef enum bit {
      REQ_MOUSE_BYTE    = 1'b0,
      REQ_READ_POSITION = 1'b1
   } req_kind_type;

   typedef enum int {
      DRIFT_NONE,
      DRIFT_GROW,
      DRIFT_SHRINK
   } drift_type;

   typedef struct {
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [2:0]            buttons;
      logic                  moved;
      logic                  done;
   } cursor_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_type = 1'b0;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [COORD_BITS-1:0] rsp_pos_x;
   logic [COORD_BITS-1:0] rsp_pos_y;
   logic [2:0]            rsp_button_bits;
   logic                  rsp_moved_flag;
   logic                  rsp_packet_done;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = 1'b0;
   logic [12:0]           csr_wdata = 13'd0;

   // Tracker model state and the screen size it clamps to.
   pmpt_pkg::phase_type   packet_phase;
   logic [7:0]            held_header;
   logic [7:0]            held_x_move;
   logic [COORD_BITS-1:0] model_x;
   logic [COORD_BITS-1:0] model_y;
   logic [2:0]            model_buttons;
   logic                  model_changed;
   logic [12:0]           screen_w;
   logic [12:0]           screen_h;

   cursor_report_type pending_reports[$];
   int fail_count = 0;
   int stalled_cycles = 0;
   int push_gap_pct = 0;
   int pop_stall_pct = 0;
   int pop_hold = 0;
   bit steady_run = 1'b0;

   ps2_mouse_packet_tracker_top #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_type(req_type),
      .req_rx_byte(req_rx_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_button_bits(rsp_button_bits),
      .rsp_moved_flag(rsp_moved_flag),
      .rsp_packet_done(rsp_packet_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [COORD_BITS-1:0] clamp_axis(logic [COORD_BITS-1:0] pos, int delta,
                                                        logic [12:0] size);
      int limit;
      int n;
      if (size == 13'd0) return '0;
      limit = (int'(size) > (1 << COORD_BITS)) ? (1 << COORD_BITS) - 1 : int'(size) - 1;
      n = int'(pos) + delta;
      if (n < 0) n = 0;
      if (n > limit) n = limit;
      return n[COORD_BITS-1:0];
   endfunction

   function automatic void reset_tracker();
      packet_phase = pmpt_pkg::PH_HEADER;
      held_header = 8'h00;
      held_x_move = 8'h00;
      model_x = pmpt_pkg::CURSOR_X_RESET[COORD_BITS-1:0];
      model_y = pmpt_pkg::CURSOR_Y_RESET[COORD_BITS-1:0];
      model_buttons = 3'd0;
      model_changed = 1'b0;
      screen_w = pmpt_pkg::WIDTH_RESET;
      screen_h = pmpt_pkg::HEIGHT_RESET;
   endfunction

   function automatic cursor_report_type track_request(req_kind_type kind, logic [7:0] b);
      cursor_report_type r;
      int dx;
      int dy;
      r.done = 1'b0;
      if (kind == REQ_READ_POSITION) begin
         r.moved = model_changed;
         model_changed = 1'b0;
      end else begin
         case (packet_phase)
            pmpt_pkg::PH_XMOVE: begin
               held_x_move = b;
               packet_phase = pmpt_pkg::PH_YMOVE;
            end
            pmpt_pkg::PH_YMOVE: begin
               dx = int'(held_x_move) - (held_header[pmpt_pkg::HDR_X_SIGN] ? 256 : 0);
               dy = -(int'(b) - (held_header[pmpt_pkg::HDR_Y_SIGN] ? 256 : 0));
               model_buttons = held_header[2:0];
               model_x = clamp_axis(model_x, dx, screen_w);
               model_y = clamp_axis(model_y, dy, screen_h);
               model_changed = 1'b1;
               packet_phase = pmpt_pkg::PH_HEADER;
               r.done = 1'b1;
            end
            default: begin
               if (b[pmpt_pkg::HDR_ALWAYS_ONE]) begin
                  held_header = b;
                  packet_phase = pmpt_pkg::PH_XMOVE;
               end else begin
                  packet_phase = pmpt_pkg::PH_HEADER;
               end
            end
         endcase
         r.moved = model_changed;
      end
      r.pos_x = model_x;
      r.pos_y = model_y;
      r.buttons = model_buttons;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_reports
      cursor_report_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual x %0d y %0d done %0d",
                     $time, rsp_pos_x, rsp_pos_y, rsp_packet_done);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("pos_x", 32'(want.pos_x), 32'(rsp_pos_x));
            check_field("pos_y", 32'(want.pos_y), 32'(rsp_pos_y));
            check_field("button_bits", 32'(want.buttons), 32'(rsp_button_bits));
            check_field("moved_flag", 32'(want.moved), 32'(rsp_moved_flag));
            check_field("packet_done", 32'(want.done), 32'(rsp_packet_done));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (pop_hold > 0) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else if (!steady_run && $urandom_range(0, 99) < pop_stall_pct) begin
            pop_hold = $urandom_range(0, 12);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_push <= 1'b0;
      req_type <= 1'($urandom);
      req_rx_byte <= 8'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_request(req_kind_type kind, logic [7:0] b);
      if (!steady_run && $urandom_range(0, 99) < push_gap_pct)
         idle_sender($urandom_range(1, 13));
      @(negedge clock);
      req_push <= 1'b1;
      req_type <= kind;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      pending_reports.push_back(track_request(kind, b));
   endtask

   task automatic send_packet(logic [7:0] header, logic [7:0] x_move, logic [7:0] y_move);
      send_request(REQ_MOUSE_BYTE, header);
      send_request(REQ_MOUSE_BYTE, x_move);
      send_request(REQ_MOUSE_BYTE, y_move);
   endtask

   task automatic wait_for_reports();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_screen(pmpt_pkg::csr_index_type idx, logic [12:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == pmpt_pkg::CSR_WIDTH)
         screen_w = value;
      else
         screen_h = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_screen(logic [12:0] w, logic [12:0] h);
      wait_for_reports();
      write_screen(pmpt_pkg::CSR_WIDTH, w);
      write_screen(pmpt_pkg::CSR_HEIGHT, h);
   endtask

   function automatic logic [7:0] pick_move();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_reset_position();
      send_request(REQ_READ_POSITION, 8'hFF);
   endtask

   task automatic test_header_sync();
      send_request(REQ_MOUSE_BYTE, 8'h00);
      send_request(REQ_MOUSE_BYTE, 8'hF7);
   endtask

   task automatic test_packet_extremes();
      send_packet(8'hFF, 8'h00, 8'h00);
      send_packet(8'h08, 8'hFF, 8'hFF);
      send_request(REQ_MOUSE_BYTE, 8'h38);
      send_request(REQ_READ_POSITION, 8'h00);
      send_request(REQ_MOUSE_BYTE, 8'h01);
      send_request(REQ_MOUSE_BYTE, 8'hFF);
      send_packet(8'h1D, 8'h80, 8'h7F);
      send_request(REQ_READ_POSITION, 8'h55);
   endtask

   task automatic test_screen_shrink();
      set_screen(13'd100, 13'd50);
      send_request(REQ_READ_POSITION, 8'hAA);
      send_packet(8'h08, 8'h00, 8'h00);
   endtask

   task automatic test_zero_screen();
      set_screen(13'd0, 13'd0);
      send_packet(8'h0F, 8'h05, 8'h05);
   endtask

   task automatic run_traffic_phase(logic [12:0] w, logic [12:0] h, drift_type drift,
                                    int gap_pct);
      int count;
      int roll;
      logic [7:0] header;
      logic [7:0] noise;
      set_screen(w, h);
      push_gap_pct = gap_pct;
      pop_stall_pct = gap_pct;
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            noise = 8'($urandom);
            send_request(REQ_MOUSE_BYTE, noise);
            count++;
         end else if (roll < 16) begin
            send_request(REQ_READ_POSITION, 8'($urandom));
            count++;
         end else begin
            header = 8'($urandom);
            header[pmpt_pkg::HDR_ALWAYS_ONE] = 1'b1;
            if (drift != DRIFT_NONE && $urandom_range(0, 4) != 0) begin
               header[pmpt_pkg::HDR_X_SIGN] = (drift == DRIFT_SHRINK);
               header[pmpt_pkg::HDR_Y_SIGN] = (drift == DRIFT_GROW);
            end
            send_request(REQ_MOUSE_BYTE, header);
            if ($urandom_range(0, 9) == 0) begin
               send_request(REQ_READ_POSITION, 8'($urandom));
               count++;
            end
            send_request(REQ_MOUSE_BYTE, pick_move());
            if ($urandom_range(0, 9) == 0) begin
               send_request(REQ_READ_POSITION, 8'($urandom));
               count++;
            end
            send_request(REQ_MOUSE_BYTE, pick_move());
            count += 3;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(13'd800, 13'd600, DRIFT_NONE, 20);
      run_traffic_phase(13'd8191, 13'd8191, DRIFT_GROW, 30);
      run_traffic_phase(13'd8191, 13'd8191, DRIFT_SHRINK, 0);
      run_traffic_phase(13'd4096, 13'd4096, DRIFT_GROW, 10);
      run_traffic_phase(13'd1, 13'd1, DRIFT_NONE, 40);
      run_traffic_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                        DRIFT_NONE, 20);
      run_traffic_phase(13'd4097, 13'd4097, DRIFT_GROW, 25);
      run_traffic_phase(13'($urandom), 13'($urandom), DRIFT_SHRINK, 15);
      run_traffic_phase(13'd640, 13'd480, DRIFT_NONE, 50);
      run_traffic_phase(13'd256, 13'd8191, DRIFT_GROW, 20);
      steady_run = 1'b1;
      run_traffic_phase(13'd800, 13'd600, DRIFT_SHRINK, 0);
      run_traffic_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                        DRIFT_NONE, 0);
   endtask

   initial begin
      reset_tracker();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_position();
      test_header_sync();
      test_packet_extremes();
      test_screen_shrink();
      test_zero_screen();
      test_random_traffic();
      wait_for_reports();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
design/pmpt_pkg.sv
design/pmpt_queue.sv
design/pmpt_front.sv
design/pmpt_back.sv
design/ps2_mouse_packet_tracker_top.sv
design/pmpt_checker.sv
dv/ps2_mouse_packet_tracker_top_test.sv
